// ===== hdl/pdfd_pkg.sv =====
// Shared types and constants of the postings document/frequency decoder.
// Used by pdfd_bitmap and postings_doc_freq_decoder; depends on nothing else.
package pdfd_pkg;

    localparam int BM_WORDS = 1024;
    localparam int BM_AW    = 10;
    localparam int WORD_W   = 64;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_WRBM  = 2'd2;
    localparam logic [1:0] OP_SKIP  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        stream_byte;
        logic [30:0]       doc_freq;
        logic [30:0]       skip_target;
        logic [BM_AW-1:0]  bitmap_index;
        logic [WORD_W-1:0] bitmap_word;
    } in_t;

    typedef struct packed {
        logic [30:0] doc_id;
        logic [30:0] frequency;
        logic        posting_valid;
        logic        last;
    } out_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BM_AW-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } bm_req_t;

endpackage

// ===== hdl/pdfd_bitmap.sv =====
// Deleted-document bitmap: 1024 x 64 single-port memory with registered read
// and a clearing sweep after reset. Depends on pdfd_pkg.
module pdfd_bitmap (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pdfd_pkg::bm_req_t     req,
    output logic [63:0]           rd_data,
    output logic                  busy
);
    import pdfd_pkg::*;

    logic [WORD_W-1:0] mem [BM_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              busy_reg, busy_next;
    logic [BM_AW-1:0]  clr_addr_reg, clr_addr_next;

    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == BM_AW'(BM_WORDS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

`ifndef SYNTHESIS
    a_no_access_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.wr_en && !req.rd_en)
        else $error("bitmap accessed during clearing sweep");
    a_sweep_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && busy_next |=> clr_addr_reg == $past(clr_addr_reg) + 1'b1)
        else $error("clearing sweep skipped an entry");
    a_sweep_ends_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> $past(clr_addr_reg) == BM_AW'(BM_WORDS - 1))
        else $error("clearing sweep ended early");
`endif

endmodule

// ===== hdl/postings_doc_freq_decoder.sv =====
// Postings document/frequency decoder: top level.
// Depends on pdfd_pkg and pdfd_bitmap.
//
//  channel  ports                       carries
//  input    s_valid s_ready s_data      one op: start, stream byte, bitmap word, skip
//  output   m_valid m_ready m_data      one decoded posting or end-of-list marker
//
// One item per cycle while s_ready is high. An item is decoded on acceptance; a
// finished posting reads the bitmap word in that cycle and is held in the
// posting stage until the output register is free, then moves on to it.
// After reset the bitmap is cleared, during which s_ready is low.
// A stalled output holds a full posting stage, and s_ready is low while it does.
module postings_doc_freq_decoder #(
    parameter int MAX_DOCS = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdfd_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pdfd_pkg::out_t    m_data
);
    import pdfd_pkg::*;

    // Decoder state
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic        expf_reg, expf_next;
    logic [30:0] doc_reg, doc_next;
    logic [30:0] remain_reg, remain_next;
    logic [30:0] target_reg, target_next;

    // Posting stage, waiting on the bitmap read
    logic        st_valid_reg, st_valid_next;
    logic [30:0] st_doc_reg, st_doc_next;
    logic [30:0] st_freq_reg, st_freq_next;
    logic        st_last_reg, st_last_next;
    logic        st_ge_reg, st_ge_next;
    logic        st_inr_reg, st_inr_next;
    logic [5:0]  st_bit_reg, st_bit_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    bm_req_t     bm_req;
    logic [63:0] bm_rd_data;
    logic        bm_busy;

    logic        accept_in;
    logic        st_move;
    logic        deleted;
    logic        keep;

    logic [31:0] shifted;
    logic [31:0] acc_new;
    logic        ends;
    logic        finish;
    logic [30:0] fin_doc;
    logic [30:0] fin_freq;
    logic [30:0] doc_add;
    logic [30:0] rem_dec;

    pdfd_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bm_req),
        .rd_data (bm_rd_data),
        .busy    (bm_busy)
    );

    assign st_move   = !m_valid_reg || m_ready;
    assign s_ready   = !bm_busy && (!st_valid_reg || st_move);
    assign accept_in = s_valid && s_ready;

    assign deleted = st_inr_reg && bm_rd_data[st_bit_reg];
    assign keep    = !deleted && st_ge_reg;

    always_comb begin
        unique case (nbytes_reg)
            3'd0:    shifted = {25'd0, s_data.stream_byte[6:0]};
            3'd1:    shifted = {18'd0, s_data.stream_byte[6:0], 7'd0};
            3'd2:    shifted = {11'd0, s_data.stream_byte[6:0], 14'd0};
            3'd3:    shifted = {4'd0, s_data.stream_byte[6:0], 21'd0};
            default: shifted = {s_data.stream_byte[3:0], 28'd0};
        endcase
    end

    assign acc_new = accum_reg | shifted;
    assign ends    = !s_data.stream_byte[7] || (nbytes_reg == 3'd4);
    assign doc_add = doc_reg + acc_new[31:1];
    assign rem_dec = remain_reg - 1'b1;

    always_comb begin
        accum_next  = accum_reg;
        nbytes_next = nbytes_reg;
        expf_next   = expf_reg;
        doc_next    = doc_reg;
        remain_next = remain_reg;
        target_next = target_reg;
        finish      = 1'b0;
        fin_doc     = doc_reg;
        fin_freq    = 31'd1;
        bm_req      = '0;

        if (accept_in) begin
            unique case (s_data.op)
                OP_START: begin
                    remain_next = s_data.doc_freq;
                    doc_next    = '0;
                    accum_next  = '0;
                    nbytes_next = '0;
                    expf_next   = 1'b0;
                end
                OP_WRBM: begin
                    bm_req.wr_en = 1'b1;
                    bm_req.addr  = s_data.bitmap_index;
                    bm_req.wdata = s_data.bitmap_word;
                end
                OP_SKIP: begin
                    target_next = s_data.skip_target;
                end
                default: begin
                    // Stream bytes after the last posting are dropped.
                    if (remain_reg != '0) begin
                        if (!ends) begin
                            accum_next  = acc_new;
                            nbytes_next = nbytes_reg + 1'b1;
                        end else begin
                            accum_next  = '0;
                            nbytes_next = '0;
                            if (expf_reg) begin
                                expf_next = 1'b0;
                                finish    = 1'b1;
                                fin_freq  = acc_new[30:0];
                            end else begin
                                doc_next = doc_add;
                                fin_doc  = doc_add;
                                if (acc_new[0]) begin
                                    finish = 1'b1;
                                end else begin
                                    expf_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            endcase
        end

        if (finish) begin
            remain_next  = rem_dec;
            bm_req.rd_en = 1'b1;
            bm_req.addr  = fin_doc[6 +: BM_AW];
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        st_doc_next   = st_doc_reg;
        st_freq_next  = st_freq_reg;
        st_last_next  = st_last_reg;
        st_ge_next    = st_ge_reg;
        st_inr_next   = st_inr_reg;
        st_bit_next   = st_bit_reg;
        if (finish) begin
            st_valid_next = 1'b1;
            st_doc_next   = fin_doc;
            st_freq_next  = fin_freq;
            st_last_next  = (rem_dec == '0);
            st_ge_next    = (fin_doc >= target_reg);
            // Documents past the bitmap or at or above MAX_DOCS are never deleted.
            st_inr_next   = ({1'b0, fin_doc} < 32'(MAX_DOCS))
                            && (fin_doc[30:6+BM_AW] == '0);
            st_bit_next   = fin_doc[5:0];
        end else if (st_move) begin
            st_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (st_move) begin
            m_valid_next               = st_valid_reg && (keep || st_last_reg);
            m_data_next.doc_id         = keep ? st_doc_reg : '0;
            m_data_next.frequency      = keep ? st_freq_reg : '0;
            m_data_next.posting_valid  = keep;
            m_data_next.last           = st_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg    <= '0;
            nbytes_reg   <= '0;
            expf_reg     <= 1'b0;
            doc_reg      <= '0;
            remain_reg   <= '0;
            target_reg   <= '0;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            accum_reg    <= accum_next;
            nbytes_reg   <= nbytes_next;
            expf_reg     <= expf_next;
            doc_reg      <= doc_next;
            remain_reg   <= remain_next;
            target_reg   <= target_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_doc_reg  <= st_doc_next;
        st_freq_reg <= st_freq_next;
        st_last_reg <= st_last_next;
        st_ge_reg   <= st_ge_next;
        st_inr_reg  <= st_inr_next;
        st_bit_reg  <= st_bit_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_busy |-> !s_ready)
        else $error("item accepted while the bitmap is being cleared");
    a_dropped_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.posting_valid || m_data_reg.last)
        else $error("dropped posting reported without end of list");
    a_vint_length: assert property (@(posedge aclk) disable iff (!aresetn)
        nbytes_reg <= 3'd4)
        else $error("integer byte count past five");
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && !st_move |=> st_valid_reg && $stable(st_doc_reg))
        else $error("posting stage lost a stalled item");
`endif

endmodule
